### sv/tspr_pkg.sv
// Shared types and constants for the terminal size report parser.
`default_nettype none
package tspr_pkg;

  localparam int REG_W = 10;
  localparam int CFG_ADDR_W = 4;
  localparam int BYTE_W = 8;
  localparam int OUT_DATA_W = 24;

  localparam logic [BYTE_W-1:0] BYTE_ESC = 8'h1b;
  localparam logic [BYTE_W-1:0] BYTE_LBRACKET = 8'h5b;
  localparam logic [BYTE_W-1:0] BYTE_SEMI = 8'h3b;
  localparam logic [BYTE_W-1:0] BYTE_R = 8'h52;
  localparam logic [BYTE_W-1:0] BYTE_ZERO = 8'h30;
  localparam logic [BYTE_W-1:0] BYTE_NINE = 8'h39;

  localparam logic [REG_W-1:0] MIN_COLS_RESET = 10'd20;
  localparam logic [REG_W-1:0] MIN_ROWS_RESET = 10'd8;
  localparam logic [REG_W-1:0] MAX_COLS_RESET = 10'd300;
  localparam logic [REG_W-1:0] MAX_ROWS_RESET = 10'd120;

  typedef enum logic [1:0] {
    REG_MIN_COLS = 2'd0,
    REG_MIN_ROWS = 2'd1,
    REG_MAX_COLS = 2'd2,
    REG_MAX_ROWS = 2'd3
  } reg_index_t;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_ESC     = 3'd1,
    PH_BRACKET = 3'd2,
    PH_ROWS    = 3'd3,
    PH_SEMI    = 3'd4,
    PH_COLS    = 3'd5
  } phase_t;

  typedef struct packed {
    logic [REG_W-1:0] min_cols;
    logic [REG_W-1:0] min_rows;
    logic [REG_W-1:0] max_cols;
    logic [REG_W-1:0] max_rows;
  } limits_t;

endpackage
`default_nettype wire

### sv/tspr_cfg.sv
// Configuration register file with an APB-style access port.
`default_nettype none
module tspr_cfg
  import tspr_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [31:0]           pwdata,
  output logic      [31:0]           prdata,
  output logic                       pready,
  output limits_t                    limits
);

  logic       wr_en;
  reg_index_t idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;
  assign idx    = reg_index_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      limits.min_cols <= MIN_COLS_RESET;
      limits.min_rows <= MIN_ROWS_RESET;
      limits.max_cols <= MAX_COLS_RESET;
      limits.max_rows <= MAX_ROWS_RESET;
    end else if (wr_en) begin
      case (idx)
        REG_MIN_COLS: limits.min_cols <= pwdata[REG_W-1:0];
        REG_MIN_ROWS: limits.min_rows <= pwdata[REG_W-1:0];
        REG_MAX_COLS: limits.max_cols <= pwdata[REG_W-1:0];
        REG_MAX_ROWS: limits.max_rows <= pwdata[REG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_MIN_COLS: prdata = {{(32-REG_W){1'b0}}, limits.min_cols};
      REG_MIN_ROWS: prdata = {{(32-REG_W){1'b0}}, limits.min_rows};
      REG_MAX_COLS: prdata = {{(32-REG_W){1'b0}}, limits.max_cols};
      REG_MAX_ROWS: prdata = {{(32-REG_W){1'b0}}, limits.max_rows};
      default:      prdata = 32'd0;
    endcase
  end

endmodule
`default_nettype wire

### sv/tspr_core.sv
// Parser state and the per-byte update of the cursor position report match.
`default_nettype none
module tspr_core
  import tspr_pkg::*;
#(
  parameter int COUNT_WIDTH = 10
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              step,
  input  wire logic [BYTE_W-1:0] in_byte,
  input  wire logic              start_over,
  input  wire limits_t           limits,
  output logic                   report_valid,
  output logic      [REG_W-1:0]  report_rows,
  output logic      [REG_W-1:0]  report_cols
);

  localparam int SUM_W = COUNT_WIDTH + 4;
  localparam int CMP_W = (COUNT_WIDTH > REG_W) ? COUNT_WIDTH : REG_W;
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

  phase_t                 phase, phase_next, ph;
  logic [COUNT_WIDTH-1:0] row_accum, row_accum_next;
  logic [COUNT_WIDTH-1:0] col_accum, col_accum_next;
  logic [COUNT_WIDTH-1:0] row_cur, col_cur, row_add, col_add;
  logic [SUM_W-1:0]       row_sum, col_sum;
  logic [CMP_W-1:0]       row_ext, col_ext;
  logic                   is_digit;
  logic [3:0]             digit;
  logic                   in_range;

  always_comb begin
    is_digit = (in_byte inside {[BYTE_ZERO:BYTE_NINE]});
    digit    = is_digit ? in_byte[3:0] : 4'd0;
    if (start_over) begin
      ph      = PH_IDLE;
      row_cur = '0;
      col_cur = '0;
    end else begin
      ph      = phase;
      row_cur = row_accum;
      col_cur = col_accum;
    end
  end

  // Multiply by ten as two shifts and an add, then saturate.
  always_comb begin
    row_sum = ({4'd0, row_cur} << 3) + ({4'd0, row_cur} << 1) + SUM_W'(digit);
    col_sum = ({4'd0, col_cur} << 3) + ({4'd0, col_cur} << 1) + SUM_W'(digit);
    row_add = (|row_sum[SUM_W-1:COUNT_WIDTH]) ? COUNT_MAX : row_sum[COUNT_WIDTH-1:0];
    col_add = (|col_sum[SUM_W-1:COUNT_WIDTH]) ? COUNT_MAX : col_sum[COUNT_WIDTH-1:0];
    row_ext = CMP_W'(row_cur);
    col_ext = CMP_W'(col_cur);
    in_range = (col_ext >= CMP_W'(limits.min_cols)) && (row_ext >= CMP_W'(limits.min_rows)) &&
               (col_ext <= CMP_W'(limits.max_cols)) && (row_ext <= CMP_W'(limits.max_rows));
  end

  always_comb begin
    phase_next = PH_IDLE;
    if (in_byte == BYTE_ESC) begin
      phase_next = PH_ESC;
    end else begin
      case (ph)
        PH_ESC: begin
          if (in_byte == BYTE_LBRACKET) phase_next = PH_BRACKET;
        end
        PH_BRACKET, PH_ROWS: begin
          if (is_digit) phase_next = PH_ROWS;
          else if (in_byte == BYTE_SEMI && ph == PH_ROWS) phase_next = PH_SEMI;
        end
        PH_SEMI, PH_COLS: begin
          if (is_digit) phase_next = PH_COLS;
        end
        default: phase_next = PH_IDLE;
      endcase
    end
  end

  always_comb begin
    row_accum_next = row_cur;
    col_accum_next = col_cur;
    report_valid   = 1'b0;
    report_rows    = '0;
    report_cols    = '0;
    case (phase_next)
      PH_IDLE, PH_ESC: begin
        row_accum_next = '0;
        col_accum_next = '0;
      end
      PH_ROWS: if (is_digit) row_accum_next = row_add;
      PH_COLS: if (is_digit) col_accum_next = col_add;
      default: ;
    endcase
    if (in_byte == BYTE_R && ph == PH_COLS && in_range) begin
      report_valid = 1'b1;
      report_rows  = row_ext[REG_W-1:0];
      report_cols  = col_ext[REG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_IDLE;
      row_accum <= '0;
      col_accum <= '0;
    end else if (step) begin
      phase     <= phase_next;
      row_accum <= row_accum_next;
      col_accum <= col_accum_next;
    end
  end

endmodule
`default_nettype wire

### sv/terminal_size_report_parser.sv
// Top level: stream registers around the parser and the configuration port.
// The accepted byte is registered, then the result is registered onto the output port.
// Throughput is one item per cycle while the output is not stalled.
// Synchronous active-high reset clears the parser state, the stream valids and
// loads the limit registers with their default values.
`default_nettype none
module terminal_size_report_parser
  import tspr_pkg::*;
#(
  parameter int COUNT_WIDTH = 10
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  input  wire logic [BYTE_W-1:0]     s_tdata,  // in_byte
  input  wire logic                  s_tuser,  // start_over
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  output logic      [OUT_DATA_W-1:0] m_tdata,  // report_rows, report_cols, zero pad
  output logic                       m_tuser,  // report_valid
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [31:0]           pwdata,
  output logic      [31:0]           prdata,
  output logic                       pready
);

  limits_t           limits;
  logic              in_valid;
  logic [BYTE_W-1:0] in_byte;
  logic              in_start_over;
  logic              out_free, step;
  logic              rep_valid;
  logic [REG_W-1:0]  rep_rows, rep_cols;

  tspr_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .limits  (limits)
  );

  tspr_core #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_core (
    .clk          (clk),
    .rst          (rst),
    .step         (step),
    .in_byte      (in_byte),
    .start_over   (in_start_over),
    .limits       (limits),
    .report_valid (rep_valid),
    .report_rows  (rep_rows),
    .report_cols  (rep_cols)
  );

  assign out_free = !m_tvalid || m_tready;
  assign step     = in_valid && out_free;
  assign s_tready = !in_valid || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte       <= s_tdata;
      in_start_over <= s_tuser;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      m_tuser <= rep_valid;
      m_tdata <= {{(OUT_DATA_W-2*REG_W){1'b0}}, rep_cols, rep_rows};
    end
  end

endmodule
`default_nettype wire
